>>> src/lwbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbc_pkg
// Shared types and constants of the write-back block cache directory.
// ----------------------------------------------------------------------------
package lwbc_pkg;

  localparam int TAG_W  = 23;
  localparam int SLOT_W = 6;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_UPD,
    S_EMIT,
    S_FLUSH,
    S_FL_END
  } state_t;

  typedef enum logic [1:0] {
    M_SCAN,
    M_UPD,
    M_FLUSH
  } mode_t;

  // controller to datapath
  typedef struct packed {
    logic  accept;
    logic  sweep;
    mode_t mode;
    logic  decide;
    logic  res_clear;
    logic  emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_done;
    logic out_free;
    logic fl_any;
  } sts_t;

endpackage

>>> src/lwbc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbc_req_if / lwbc_rsp_if
// Valid/ready channels for access words and result words.
// ----------------------------------------------------------------------------
interface lwbc_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 op;
  logic [lwbc_pkg::TAG_W-1:0] blk_num;

  modport source (output valid, output op, output blk_num, input ready);
  modport sink (input valid, input op, input blk_num, output ready);
endinterface

interface lwbc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [lwbc_pkg::SLOT_W-1:0] slot;
  logic                        fill;
  logic                        wb_valid;
  logic [lwbc_pkg::TAG_W-1:0]  wb_block;
  logic [lwbc_pkg::SLOT_W-1:0] wb_slot;
  logic                        last;

  modport source (output valid, output hit, output slot, output fill, output wb_valid,
                  output wb_block, output wb_slot, output last, input ready);
  modport sink (input valid, input hit, input slot, input fill, input wb_valid,
                input wb_block, input wb_slot, input last, output ready);
endinterface

>>> src/lru_writeback_block_cache.sv
`timescale 1ns / 1ps
// Read or write access: tag scan, decision and recency sweep, then the result word
// is issued once the output register is free.
// Flush: one walk over all slots, one word per dirty slot, held by any output stalls;
// with no dirty slot, a single clean last word follows the walk.
// One access at a time: the next access is taken after the result word is issued.
// Synchronous active-high reset empties the directory at once; no clearing pass.
// ----------------------------------------------------------------------------
// lru_writeback_block_cache
// Fully associative write-back block cache directory with LRU replacement.
// ----------------------------------------------------------------------------
module lru_writeback_block_cache #(
  parameter int SLOTS = 64
) (
  input logic       clk,
  input logic       rst,
  lwbc_req_if.sink  req,
  lwbc_rsp_if.source rsp
);

  lwbc_pkg::cmd_t cmd;
  lwbc_pkg::sts_t sts;

  // sequencer
  lwbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_op    (req.op),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // directory datapath
  lwbc_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (req.op),
    .in_blk_num (req.blk_num),
    .rsp        (rsp)
  );

endmodule

>>> src/lwbc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbc_ctrl
// Sequencer: tag scan, decision, recency sweep, result issue and flush walk.
// ----------------------------------------------------------------------------
module lwbc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [1:0]      in_op,
  output logic            in_ready,
  input  lwbc_pkg::sts_t  sts,
  output lwbc_pkg::cmd_t  cmd
);

  lwbc_pkg::state_t state, state_next;
  lwbc_pkg::op_t    op_in;

  assign op_in = lwbc_pkg::op_t'(in_op);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lwbc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lwbc_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (op_in)
            lwbc_pkg::OP_READ, lwbc_pkg::OP_WRITE: state_next = lwbc_pkg::S_SCAN;
            lwbc_pkg::OP_FLUSH:                    state_next = lwbc_pkg::S_FLUSH;
            default:                               state_next = lwbc_pkg::S_IDLE;
          endcase
        end
      end
      lwbc_pkg::S_SCAN:   if (sts.sweep_done) state_next = lwbc_pkg::S_DECIDE;
      lwbc_pkg::S_DECIDE: state_next = lwbc_pkg::S_UPD;
      lwbc_pkg::S_UPD:    if (sts.sweep_done) state_next = lwbc_pkg::S_EMIT;
      lwbc_pkg::S_EMIT:   if (sts.out_free) state_next = lwbc_pkg::S_IDLE;
      lwbc_pkg::S_FLUSH:  if (sts.sweep_done) state_next = lwbc_pkg::S_FL_END;
      lwbc_pkg::S_FL_END: state_next = sts.fl_any ? lwbc_pkg::S_IDLE : lwbc_pkg::S_EMIT;
      default:            state_next = lwbc_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.sweep     = 1'b0;
    cmd.mode      = lwbc_pkg::M_SCAN;
    cmd.decide    = 1'b0;
    cmd.res_clear = 1'b0;
    cmd.emit      = 1'b0;
    unique case (state)
      lwbc_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      lwbc_pkg::S_SCAN: begin
        cmd.sweep = 1'b1;
        cmd.mode  = lwbc_pkg::M_SCAN;
      end
      lwbc_pkg::S_DECIDE: cmd.decide = 1'b1;
      lwbc_pkg::S_UPD: begin
        cmd.sweep = 1'b1;
        cmd.mode  = lwbc_pkg::M_UPD;
      end
      lwbc_pkg::S_EMIT:   cmd.emit = 1'b1;
      lwbc_pkg::S_FLUSH: begin
        cmd.sweep = 1'b1;
        cmd.mode  = lwbc_pkg::M_FLUSH;
      end
      lwbc_pkg::S_FL_END: cmd.res_clear = 1'b1;
      default: ;
    endcase
  end

endmodule

>>> src/lwbc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbc_dp
// Directory datapath: tag and recency memories, slot flags, sweep counter,
// scan results and the output register.
// ----------------------------------------------------------------------------
module lwbc_dp #(
  parameter int SLOTS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  lwbc_pkg::cmd_t cmd,
  output lwbc_pkg::sts_t sts,
  input  logic [1:0]     in_op,
  input  logic [lwbc_pkg::TAG_W-1:0] in_blk_num,
  lwbc_rsp_if.source     rsp
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  // storage
  logic [lwbc_pkg::TAG_W-1:0] tag_mem [SLOTS];
  logic [IW-1:0]              rank_mem [SLOTS];
  logic [SLOTS-1:0]           used, dirty;

  // access word
  lwbc_pkg::op_t              op;
  logic [lwbc_pkg::TAG_W-1:0] blk;

  // sweep pipeline
  logic [CW-1:0]              cnt;
  logic                       pvld;
  logic [IW-1:0]              pidx;
  logic [lwbc_pkg::TAG_W-1:0] tag_q;
  logic [IW-1:0]              rank_q;
  logic                       adv, du_cur, more_dirty, fl_emit, cnt_live;

  // scan results
  logic                       hit_f, free_f, vic_f, vic_dirty, fl_any;
  logic [IW-1:0]              s_hit, s_free, s_vic, tgt;
  logic [IW-1:0]              hit_rank;
  logic [lwbc_pkg::TAG_W-1:0] vic_tag;
  logic [CW-1:0]              old_rank;

  // pending result
  logic                        r_hit, r_fill, r_wbv;
  logic [lwbc_pkg::SLOT_W-1:0] r_slot, r_wbs;
  logic [lwbc_pkg::TAG_W-1:0]  r_wbb;

  logic                        out_free, out_load;
  logic                        rank_we;
  logic [IW-1:0]               rank_wd;

  // sweep control
  assign cnt_live = cnt < CW'(SLOTS);
  assign du_cur   = used[pidx] & dirty[pidx];
  assign out_free = !rsp.valid || rsp.ready;
  assign adv      = !(pvld && cmd.mode == lwbc_pkg::M_FLUSH && du_cur && !out_free);
  assign fl_emit  = cmd.sweep && cmd.mode == lwbc_pkg::M_FLUSH && pvld && du_cur && out_free;

  // any dirty slot above the current one
  always_comb begin
    more_dirty = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      if (IW'(j) > pidx && used[j] && dirty[j]) more_dirty = 1'b1;
    end
  end

  // target selection
  assign tgt      = hit_f ? s_hit : (free_f ? s_free : s_vic);
  assign old_rank = hit_f ? CW'(hit_rank) : CW'(SLOTS);

  assign sts.sweep_done = (cnt == CW'(SLOTS)) && !pvld;
  assign sts.out_free   = out_free;
  assign sts.fl_any     = fl_any;

  // counter and valid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      pvld <= 1'b0;
    end else if (cmd.accept || cmd.decide) begin
      cnt  <= '0;
      pvld <= 1'b0;
    end else if (cmd.sweep && adv) begin
      pvld <= cnt_live;
      if (cnt_live) cnt <= cnt + 1'b1;
    end
  end

  // memory reads
  always_ff @(posedge clk) begin
    if (cmd.sweep && adv && cnt_live) begin
      tag_q  <= tag_mem[cnt[IW-1:0]];
      rank_q <= rank_mem[cnt[IW-1:0]];
      pidx   <= cnt[IW-1:0];
    end
  end

  // tag write on a miss
  always_ff @(posedge clk) begin
    if (cmd.decide && !hit_f) tag_mem[tgt] <= blk;
  end

  // recency update
  always_comb begin
    rank_we = 1'b0;
    rank_wd = rank_q + 1'b1;
    if (cmd.sweep && cmd.mode == lwbc_pkg::M_UPD && pvld) begin
      if (pidx == tgt) begin
        rank_we = 1'b1;
        rank_wd = '0;
      end else if (used[pidx] && CW'(rank_q) < old_rank) begin
        rank_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rank_we) rank_mem[pidx] <= rank_wd;
  end

  // access latch and scan flags
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_f  <= 1'b0;
      free_f <= 1'b0;
      vic_f  <= 1'b0;
      fl_any <= 1'b0;
      op     <= lwbc_pkg::OP_NONE;
    end else if (cmd.accept) begin
      hit_f  <= 1'b0;
      free_f <= 1'b0;
      vic_f  <= 1'b0;
      fl_any <= 1'b0;
      op     <= lwbc_pkg::op_t'(in_op);
    end else begin
      if (cmd.sweep && cmd.mode == lwbc_pkg::M_SCAN && pvld) begin
        if (used[pidx] && tag_q == blk && !hit_f) hit_f <= 1'b1;
        if (!used[pidx] && !free_f) free_f <= 1'b1;
        if (used[pidx] && rank_q == IW'(SLOTS - 1)) vic_f <= 1'b1;
      end
      if (fl_emit) fl_any <= 1'b1;
    end
  end

  // scan payload
  always_ff @(posedge clk) begin
    if (cmd.accept) blk <= in_blk_num;
    if (cmd.sweep && cmd.mode == lwbc_pkg::M_SCAN && pvld) begin
      if (used[pidx] && tag_q == blk && !hit_f) begin
        s_hit    <= pidx;
        hit_rank <= rank_q;
      end
      if (!used[pidx] && !free_f) s_free <= pidx;
      if (used[pidx] && rank_q == IW'(SLOTS - 1)) begin
        s_vic     <= pidx;
        vic_tag   <= tag_q;
        vic_dirty <= dirty[pidx];
      end
    end
  end

  // slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      dirty <= '0;
    end else begin
      if (cmd.decide) begin
        used[tgt] <= 1'b1;
        if (hit_f) begin
          if (op == lwbc_pkg::OP_WRITE) dirty[tgt] <= 1'b1;
        end else begin
          dirty[tgt] <= (op == lwbc_pkg::OP_WRITE);
        end
      end
      if (fl_emit) dirty[pidx] <= 1'b0;
    end
  end

  // pending result word
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      r_hit  <= hit_f;
      r_slot <= lwbc_pkg::SLOT_W'(tgt);
      r_fill <= !hit_f;
      r_wbv  <= !hit_f && !free_f && vic_dirty;
      r_wbb  <= (!hit_f && !free_f && vic_dirty) ? vic_tag : '0;
      r_wbs  <= (!hit_f && !free_f && vic_dirty) ? lwbc_pkg::SLOT_W'(s_vic) : '0;
    end else if (cmd.res_clear) begin
      r_hit  <= 1'b0;
      r_slot <= '0;
      r_fill <= 1'b0;
      r_wbv  <= 1'b0;
      r_wbb  <= '0;
      r_wbs  <= '0;
    end
  end

  // output register
  assign out_load = fl_emit || (cmd.emit && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fl_emit) begin
      rsp.hit      <= 1'b0;
      rsp.slot     <= '0;
      rsp.fill     <= 1'b0;
      rsp.wb_valid <= 1'b1;
      rsp.wb_block <= tag_q;
      rsp.wb_slot  <= lwbc_pkg::SLOT_W'(pidx);
      rsp.last     <= !more_dirty;
    end else if (cmd.emit && out_free) begin
      rsp.hit      <= r_hit;
      rsp.slot     <= r_slot;
      rsp.fill     <= r_fill;
      rsp.wb_valid <= r_wbv;
      rsp.wb_block <= r_wbb;
      rsp.wb_slot  <= r_wbs;
      rsp.last     <= 1'b1;
    end
  end

`ifndef ASSERT_OFF
  // a full directory always has a least recently used slot
  a_victim: assert property (@(posedge clk) disable iff (rst)
    cmd.decide && !hit_f && !free_f |-> vic_f)
    else $error("no victim found in a full directory");

  // decision only after the scan has drained
  a_decide: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> $past(sts.sweep_done))
    else $error("decision before scan completed");

  // a flushed slot is clean afterwards
  a_flush_clean: assert property (@(posedge clk) disable iff (rst)
    fl_emit |=> !dirty[$past(pidx)])
    else $error("flushed slot still dirty");
`endif

endmodule
